// File: hdl/cst_pkg.sv
`default_nettype none
package cst_pkg;

	localparam int KEY_BITS = 10;
	localparam int IN_BITS  = 10;
	localparam int NB       = KEY_BITS + 1;
	localparam int QW       = KEY_BITS + 2;
	localparam int CNT_BITS = 32;

	typedef logic [NB-1:0]       node_t;
	typedef logic [QW-1:0]       bound_t;
	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [2:0]          step_t;

	localparam step_t S_CLR   = 3'd0;
	localparam step_t S_IDLE  = 3'd1;
	localparam step_t S_QCHK  = 3'd2;
	localparam step_t S_QRGT  = 3'd3;
	localparam step_t S_QSHF  = 3'd4;
	localparam step_t S_OUT   = 3'd5;
	localparam step_t S_IREAD = 3'd6;
	localparam step_t S_IWRT  = 3'd7;

	typedef enum logic [3:0] {
		OP_NOP    = 4'd0,
		OP_CLR    = 4'd1,
		OP_LOAD   = 4'd2,
		OP_QLEFT  = 4'd3,
		OP_QRIGHT = 4'd4,
		OP_QSHIFT = 4'd5,
		OP_OUT    = 4'd6,
		OP_IREAD  = 4'd7,
		OP_IWRITE = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER        = 3'd0,
		C_ALWAYS       = 3'd1,
		C_NOT_CLR_LAST = 3'd2,
		C_NOT_START    = 3'd3,
		C_Q_DONE       = 3'd4,
		C_NOT_ROOT     = 3'd5
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump_to;
		step_t else_to;
	} uword_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic q_done;
		logic clr_last;
		logic at_root;
	} stat_t;

	function automatic uword_t ucode_rom(input step_t s);
		uword_t w;
		case (s)
			S_CLR:   w = '{OP_CLR,    C_NOT_CLR_LAST, S_CLR,   S_IDLE};
			S_IDLE:  w = '{OP_LOAD,   C_NOT_START,    S_IDLE,  S_QCHK};
			S_QCHK:  w = '{OP_QLEFT,  C_Q_DONE,       S_OUT,   S_QRGT};
			S_QRGT:  w = '{OP_QRIGHT, C_NEVER,        S_QRGT,  S_QSHF};
			S_QSHF:  w = '{OP_QSHIFT, C_ALWAYS,       S_QCHK,  S_QCHK};
			S_OUT:   w = '{OP_OUT,    C_NEVER,        S_OUT,   S_IREAD};
			S_IREAD: w = '{OP_IREAD,  C_NEVER,        S_IREAD, S_IWRT};
			S_IWRT:  w = '{OP_IWRITE, C_NOT_ROOT,     S_IREAD, S_IDLE};
			default: w = '{OP_NOP,    C_ALWAYS,       S_IDLE,  S_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [KEY_BITS-1:0] fit_key(input logic [IN_BITS-1:0] v);
		logic [IN_BITS+KEY_BITS-1:0] w;
		w = {{KEY_BITS{1'b0}}, v};
		return w[KEY_BITS-1:0];
	endfunction

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [CNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// File: hdl/cst_useq.sv
`default_nettype none
module cst_useq
	import cst_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	step_t  step_q;
	uword_t cw;
	logic   take;

	assign cw = ucode_rom(step_q);
	assign busy = (step_q != S_IDLE);

	always_comb begin
		case (cw.cond)
			C_NEVER:        take = 1'b0;
			C_ALWAYS:       take = 1'b1;
			C_NOT_CLR_LAST: take = !stat.clr_last;
			C_NOT_START:    take = !start;
			C_Q_DONE:       take = stat.q_done;
			C_NOT_ROOT:     take = !stat.at_root;
			default:        take = 1'b1;
		endcase
	end

	always_comb begin
		ctrl.op = cw.op;
		if (cw.op == OP_LOAD && !start) begin
			ctrl.op = OP_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_CLR;
		end else begin
			step_q <= take ? cw.jump_to : cw.else_to;
		end
	end

endmodule
`default_nettype wire

// File: hdl/cst_datapath.sv
`default_nettype none
module cst_datapath
	import cst_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  ctrl_t               ctrl,
	input  wire  [IN_BITS-1:0]  range_low,
	input  wire  [IN_BITS-1:0]  range_high,
	input  wire  [IN_BITS-1:0]  insert_key,
	output stat_t               stat,
	output cnt_t                range_count,
	output logic                done
);

	cnt_t   mem [2**NB];
	bound_t l_q, r_q, r_dec;
	node_t  n_q;
	cnt_t   acc_q, rdata_q, result_q, wdata;
	logic   pend_q, done_q;
	logic   we, re, l_take;
	node_t  waddr, raddr;

	assign r_dec  = r_q - QW'(1);
	assign l_take = (l_q < r_q) && l_q[0];

	assign stat.q_done   = !(l_q < r_q);
	assign stat.clr_last = &n_q;
	assign stat.at_root  = (n_q == NB'(1));

	assign range_count = result_q;
	assign done        = done_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = n_q;
		raddr = n_q;
		wdata = '0;
		case (ctrl.op)
			OP_CLR: begin
				we = 1'b1;
			end
			OP_QLEFT: begin
				re    = l_take;
				raddr = l_q[NB-1:0];
			end
			OP_QRIGHT: begin
				re    = r_q[0];
				raddr = r_dec[NB-1:0];
			end
			OP_IREAD: begin
				re = 1'b1;
			end
			OP_IWRITE: begin
				we    = 1'b1;
				wdata = sat_add(rdata_q, CNT_BITS'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_OUT) begin
			result_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q    <= '0;
			r_q    <= '0;
			n_q    <= '0;
			acc_q  <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ctrl.op)
				OP_CLR: begin
					n_q <= n_q + NB'(1);
				end
				OP_LOAD: begin
					l_q    <= {2'b01, fit_key(range_low)};
					r_q    <= {2'b01, fit_key(range_high)} + QW'(1);
					n_q    <= {1'b1, fit_key(insert_key)};
					acc_q  <= '0;
					pend_q <= 1'b0;
				end
				OP_QLEFT: begin
					pend_q <= l_take;
					if (l_take) begin
						l_q <= l_q + QW'(1);
					end
				end
				OP_QRIGHT: begin
					if (pend_q) begin
						acc_q <= sat_add(acc_q, rdata_q);
					end
					pend_q <= r_q[0];
					if (r_q[0]) begin
						r_q <= r_dec;
					end
				end
				OP_QSHIFT: begin
					if (pend_q) begin
						acc_q <= sat_add(acc_q, rdata_q);
					end
					pend_q <= 1'b0;
					l_q    <= l_q >> 1;
					r_q    <= r_q >> 1;
				end
				OP_OUT: begin
					done_q <= 1'b1;
				end
				OP_IWRITE: begin
					n_q <= n_q >> 1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/count_segment_tree_core.sv
// channel    | signals                                        | transaction when
// -----------+------------------------------------------------+--------------------------
// command    | start, busy, range_low, range_high, insert_key | start high and busy low
// result     | done, range_count                              | done high (one cycle)
//
// after acceptance an item occupies the block while it walks the tree levels with a
// left, right and shift step each (up to KEY_BITS+1 levels), exits the query, gives
// the result and reads and then writes each node on the insert path, leaf to root.
// after reset a clearing pass zeroes every node of the memory, busy high.
// done follows one query check and the result step at best; the receiver cannot stall.
`default_nettype none
module count_segment_tree_core
	import cst_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [IN_BITS-1:0] range_low,
	input  wire  [IN_BITS-1:0] range_high,
	input  wire  [IN_BITS-1:0] insert_key,
	output cnt_t               range_count,
	output logic               done
);

	ctrl_t ctrl;
	stat_t stat;

	cst_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	cst_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.range_low   (range_low),
		.range_high  (range_high),
		.insert_key  (insert_key),
		.stat        (stat),
		.range_count (range_count),
		.done        (done)
	);

endmodule
`default_nettype wire

// File: hdl/cst_checker.sv
`default_nettype none
module cst_checker
	import cst_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire [IN_BITS-1:0] range_low,
	input wire [IN_BITS-1:0] range_high,
	input wire [IN_BITS-1:0] insert_key,
	input wire [CNT_BITS-1:0] range_count,
	input wire               done
);

	logic accept;
	logic empty;

	assign accept = start && !busy;
	assign empty  = fit_key(range_low) > fit_key(range_high);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result delivered while idle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_empty_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty) |-> ##3 (done && range_count == '0))
		else $error("empty range did not return zero on time");

endmodule

bind count_segment_tree_core cst_checker u_cst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.range_low   (range_low),
	.range_high  (range_high),
	.insert_key  (insert_key),
	.range_count (range_count),
	.done        (done)
);
`default_nettype wire

// File: tb/count_segment_tree_checker.sv
`default_nettype none
module count_segment_tree_checker
	import cst_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 busy,
	input  wire  [IN_BITS-1:0]  range_low,
	input  wire  [IN_BITS-1:0]  range_high,
	input  wire  [IN_BITS-1:0]  insert_key,
	input  wire  [CNT_BITS-1:0] range_count,
	input  wire                 done,
	output int unsigned         fail_count,
	output int unsigned         pending_count,
	output int unsigned         checked_count
);

	localparam int unsigned LEAVES = 1 << KEY_BITS;
	localparam int unsigned NODES  = 1 << NB;

	// shadow copy of the counter tree, node 1 is the root
	cnt_t        tree_cnt [NODES];
	cnt_t        count_queue [$];
	cnt_t        want;
	int unsigned fail_total;
	int unsigned checked_total;

	function automatic cnt_t count_in_range(input logic [KEY_BITS-1:0] lo,
	                                        input logic [KEY_BITS-1:0] hi);
		bound_t               l;
		bound_t               r;
		logic [CNT_BITS+NB:0] acc;
		acc = '0;
		if (lo > hi)
			return '0;
		l = bound_t'(lo) + bound_t'(LEAVES);
		r = bound_t'(hi) + bound_t'(LEAVES) + bound_t'(1);
		while (l < r) begin
			if (l[0]) begin
				acc += tree_cnt[node_t'(l)];
				l++;
			end
			if (r[0]) begin
				r--;
				acc += tree_cnt[node_t'(r)];
			end
			l >>= 1;
			r >>= 1;
		end
		return (acc > {CNT_BITS{1'b1}}) ? {CNT_BITS{1'b1}} : acc[CNT_BITS-1:0];
	endfunction

	// bump the leaf and every ancestor, saturating
	function automatic void add_key(input logic [KEY_BITS-1:0] key);
		node_t n;
		n = {1'b1, key};
		while (n != '0) begin
			if (tree_cnt[n] != {CNT_BITS{1'b1}})
				tree_cnt[n] = tree_cnt[n] + 1'b1;
			n >>= 1;
		end
	endfunction

	task automatic report_mismatch(input string what, input cnt_t exp_val, input cnt_t got_val);
		$display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, exp_val, got_val);
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				tree_cnt[i] = '0;
			count_queue.delete();
			fail_total    = 0;
			checked_total = 0;
			fail_count    <= 0;
			pending_count <= 0;
			checked_count <= 0;
		end else begin
			// result first, so a transaction in the same cycle queues behind it
			if (done === 1'b1) begin
				if (count_queue.size() == 0) begin
					report_mismatch("result with no transaction waiting", '0, range_count);
				end else begin
					want = count_queue.pop_front();
					checked_total++;
					if (range_count !== want)
						report_mismatch("range_count", want, range_count);
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				count_queue.push_back(count_in_range(range_low[KEY_BITS-1:0],
				                                     range_high[KEY_BITS-1:0]));
				add_key(insert_key[KEY_BITS-1:0]);
			end
			fail_count    <= fail_total;
			pending_count <= count_queue.size();
			checked_count <= checked_total;
		end
	end

endmodule
`default_nettype wire

// File: tb/count_segment_tree_core_test.sv
`default_nettype none
module count_segment_tree_core_test;
	import cst_pkg::*;

	localparam int unsigned ITEM_TOTAL   = 1500;
	localparam int unsigned STALL_LIMIT  = 20000;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned MAX_GAP      = 64;
	localparam int unsigned KEY_TOP      = (1 << KEY_BITS) - 1;

	localparam int unsigned IDLE_NONE  = 0;
	localparam int unsigned IDLE_LIGHT = 25;
	localparam int unsigned IDLE_HEAVY = 71;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [IN_BITS-1:0] range_low = '0;
	logic [IN_BITS-1:0] range_high = '0;
	logic [IN_BITS-1:0] insert_key = '0;
	logic               busy;
	logic               done;
	cnt_t               range_count;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned checked_count;
	int unsigned idle_pct = IDLE_NONE;
	int unsigned items_sent = 0;
	int unsigned empty_sent = 0;
	int unsigned quiet_cycles = 0;

	count_segment_tree_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.range_low  (range_low),
		.range_high (range_high),
		.insert_key (insert_key),
		.range_count(range_count),
		.done       (done)
	);

	count_segment_tree_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.range_low    (range_low),
		.range_high   (range_high),
		.insert_key   (insert_key),
		.range_count  (range_count),
		.done         (done),
		.fail_count   (fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// returns right after the edge at which the command was taken
	task automatic send_cmd(input logic [IN_BITS-1:0] lo, input logic [IN_BITS-1:0] hi,
	                        input logic [IN_BITS-1:0] key);
		int unsigned gap;
		gap = 0;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct)
			gap = $urandom_range(MAX_GAP, 1);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		range_low  <= lo;
		range_high <= hi;
		insert_key <= key;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		items_sent++;
		if (lo > hi)
			empty_sent++;
	endtask

	task automatic drain;
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	function automatic logic [IN_BITS-1:0] pick_key;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 65)
			return IN_BITS'($urandom);
		else if (sel < 80)
			return IN_BITS'($urandom_range(15));
		else if (sel < 92)
			return IN_BITS'($urandom_range(KEY_TOP, KEY_TOP - 15));
		else
			return ($urandom_range(1) != 0) ? IN_BITS'(KEY_TOP) : '0;
	endfunction

	task automatic send_random;
		logic [IN_BITS-1:0] a;
		logic [IN_BITS-1:0] b;
		logic [IN_BITS-1:0] lo;
		logic [IN_BITS-1:0] hi;
		int unsigned        sel;
		a   = pick_key();
		b   = pick_key();
		sel = $urandom_range(99);
		if (sel < 55) begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
		end else if (sel < 67) begin
			lo = a;
			hi = (int'(a) + 7 > KEY_TOP) ? IN_BITS'(KEY_TOP) : a + IN_BITS'($urandom_range(7));
		end else if (sel < 75) begin
			if (a == b)
				b = a ^ IN_BITS'(1);
			lo = (a > b) ? a : b;
			hi = (a > b) ? b : a;
		end else if (sel < 85) begin
			lo = ($urandom_range(1) != 0) ? '0 : a;
			hi = (lo == '0 && $urandom_range(1) != 0) ? a : IN_BITS'(KEY_TOP);
		end else begin
			lo = IN_BITS'($urandom);
			hi = IN_BITS'($urandom);
		end
		send_cmd(lo, hi, pick_key());
	endtask

	initial begin
		int unsigned phase_idle [4];
		phase_idle = '{IDLE_NONE, IDLE_HEAVY, IDLE_NONE, IDLE_LIGHT};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, empty ranges, own insert not counted
		idle_pct = IDLE_NONE;
		send_cmd(10'd0,    10'd1023, 10'd0);
		send_cmd(10'd0,    10'd1023, 10'd1023);
		send_cmd(10'd0,    10'd0,    10'd0);
		send_cmd(10'd1023, 10'd1023, 10'd1023);
		send_cmd(10'd0,    10'd1023, 10'd512);
		send_cmd(10'd1023, 10'd0,    10'd511);
		send_cmd(10'd512,  10'd511,  10'd512);
		send_cmd(10'd511,  10'd512,  10'd5);
		send_cmd(10'd1,    10'd1022, 10'd5);
		send_cmd(10'd5,    10'd5,    10'd5);
		send_cmd(10'd5,    10'd5,    10'd1);
		send_cmd(10'd0,    10'd1,    10'd1022);
		send_cmd(10'd1022, 10'd1023, 10'd0);
		send_cmd(10'd341,  10'd682,  10'd341);
		send_cmd(10'd682,  10'd341,  10'd682);
		send_cmd(10'd0,    10'd511,  10'd1023);
		send_cmd(10'd512,  10'd1023, 10'd0);
		send_cmd(10'd1,    10'd1,    10'd1);
		send_cmd(10'd1023, 10'd1023, 10'd0);
		send_cmd(10'h2AA,  10'h355,  10'h155);
		send_cmd(10'h155,  10'h2AA,  10'h2AA);
		send_cmd(10'd0,    10'd1023, 10'd0);
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			for (int i = 0; i < ITEM_TOTAL / 4; i++)
				send_random();
			if (p == 1)
				drain();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d with an empty range; %0d range counts checked",
		         items_sent, empty_sent, checked_count);
		$display("sender gaps before 0, 25 and 71 percent of commands, results drained");
		$display("after the directed set and after the heavy-idle phase");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
hdl/cst_pkg.sv
hdl/cst_useq.sv
hdl/cst_datapath.sv
hdl/count_segment_tree_core.sv
hdl/cst_checker.sv
tb/count_segment_tree_checker.sv
tb/count_segment_tree_core_test.sv
